@@ rtl/fsc_pkg.sv @@
// Package for the frustum sphere culling block: payload types, register
// indexes and fixed constants. It depends on nothing else.
`default_nettype none

package fsc_pkg;

	localparam int NUM_PLANES = 4;
	localparam int NUM_AXES   = 3;

	localparam logic signed [31:0] CULLED_DEPTH = 32'sh7FFF_FFFF;
	localparam logic [11:0]        ROUND_BIAS   = 12'h800;
	localparam int                 FRAC_BITS    = 12;

	typedef enum logic [2:0] {
		REG_NEAR   = 3'd0,
		REG_FAR    = 3'd1,
		REG_PLANE0 = 3'd2,
		REG_PLANE1 = 3'd3,
		REG_PLANE2 = 3'd4,
		REG_PLANE3 = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [31:0] radius;
		logic               use_hint;
		logic [7:0]         hint_in;
	} sphere_item_t;

	typedef struct packed {
		logic signed [31:0] depth;
		logic [7:0]         new_hint;
	} cull_item_t;

endpackage

`default_nettype wire

@@ rtl/fsc_if.sv @@
// Valid/ready channel interfaces for sphere items and cull results.
// Payload types come from fsc_pkg.
`default_nettype none

interface fsc_sphere_if;
	logic                  valid;
	logic                  ready;
	fsc_pkg::sphere_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface fsc_cull_if;
	logic                valid;
	logic                ready;
	fsc_pkg::cull_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/frustum_sphere_cull.sv @@
// Top level of the frustum sphere culling block: APB register file and a
// three-stage pipeline. Depends on fsc_pkg and the channel interfaces in fsc_if.
//
// A sphere (centre and radius in 20.12) arrives on the sphere channel; one
// result (depth or the culled marker, and the hint) leaves on the result
// channel for every sphere, in order. A transfer is taken in the input
// register, the twelve coordinate by normal products are registered in the
// second stage, and the sums, compares and hint selection load the result
// register, which drives the result channel directly. One sphere can be
// taken every cycle while the stages are not all full; each stage holds one
// item and moves on when the stage after it is empty or moving, so a stalled
// receiver fills the three stages before ready falls. Registers are written
// through the APB port at byte address 8*index and are read back on prdata.
// Reset clears the stage valid flags and the configuration registers to zero.
`default_nettype none

module frustum_sphere_cull (
	input  wire logic        clk,
	input  wire logic        arst_n,
	fsc_sphere_if.sink       sphere,
	fsc_cull_if.source       result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready
);
	import fsc_pkg::*;

	logic signed [31:0] near_q;
	logic signed [31:0] far_q;
	logic [47:0]        normal_q [NUM_PLANES];
	reg_idx_t           reg_idx;
	logic               cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[5:3]);
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= '0;
			far_q  <= '0;
			for (int k = 0; k < NUM_PLANES; k++) begin
				normal_q[k] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_NEAR:   near_q      <= $signed(pwdata[31:0]);
				REG_FAR:    far_q       <= $signed(pwdata[31:0]);
				REG_PLANE0: normal_q[0] <= pwdata[47:0];
				REG_PLANE1: normal_q[1] <= pwdata[47:0];
				REG_PLANE2: normal_q[2] <= pwdata[47:0];
				REG_PLANE3: normal_q[3] <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_NEAR:   prdata = {32'd0, near_q};
			REG_FAR:    prdata = {32'd0, far_q};
			REG_PLANE0: prdata = {16'd0, normal_q[0]};
			REG_PLANE1: prdata = {16'd0, normal_q[1]};
			REG_PLANE2: prdata = {16'd0, normal_q[2]};
			REG_PLANE3: prdata = {16'd0, normal_q[3]};
			default:    prdata = '0;
		endcase
	end

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	assign en3 = !v_s3 || result.ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign sphere.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= sphere.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	sphere_item_t item_s1;

	always_ff @(posedge clk) begin
		if (en1) item_s1 <= sphere.data;
	end

	logic signed [31:0] coord [NUM_AXES];
	logic signed [47:0] prod  [NUM_PLANES][NUM_AXES];
	logic signed [31:0] depth_c, lo_c, hi_c;
	logic               nf_ok_c;

	always_comb begin
		coord[0] = item_s1.point_x;
		coord[1] = item_s1.point_y;
		coord[2] = item_s1.point_z;
		for (int k = 0; k < NUM_PLANES; k++) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				prod[k][a] = coord[a] * $signed(normal_q[k][16*a +: 16]);
			end
		end
		depth_c = 32'sd0 - item_s1.point_z;
		lo_c    = near_q - item_s1.radius;
		hi_c    = far_q + item_s1.radius;
		nf_ok_c = !((depth_c < lo_c) || (depth_c > hi_c));
	end

	logic signed [47:0] prod_s2 [NUM_PLANES][NUM_AXES];
	logic signed [31:0] rad_s2, depth_s2;
	logic               nf_ok_s2, use_hint_s2;
	logic [7:0]         hint_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			prod_s2     <= prod;
			rad_s2      <= item_s1.radius;
			depth_s2    <= depth_c;
			nf_ok_s2    <= nf_ok_c;
			use_hint_s2 <= item_s1.use_hint;
			hint_s2     <= item_s1.hint_in;
		end
	end

	logic signed [49:0] sum_h   [NUM_PLANES];
	logic signed [49:0] dist_h  [NUM_PLANES];
	logic signed [31:0] rp      [NUM_PLANES][NUM_AXES];
	logic signed [31:0] sum_p   [NUM_PLANES];
	logic signed [49:0] rad_x;
	logic [NUM_PLANES-1:0] fail_h, fail_p;
	logic [1:0]         first, idx, fidx;
	logic               found, culled;
	cull_item_t         res_c;

	always_comb begin
		rad_x = 50'(rad_s2);
		for (int k = 0; k < NUM_PLANES; k++) begin
			sum_h[k]  = 50'(prod_s2[k][0]) + 50'(prod_s2[k][1]) + 50'(prod_s2[k][2]);
			dist_h[k] = (sum_h[k] + $signed({38'd0, ROUND_BIAS})) >>> FRAC_BITS;
			fail_h[k] = dist_h[k] > rad_x;
			for (int a = 0; a < NUM_AXES; a++) begin
				rp[k][a] = 32'((prod_s2[k][a] + $signed({36'd0, ROUND_BIAS})) >>> FRAC_BITS);
			end
			sum_p[k]  = rp[k][2] + (rp[k][0] + rp[k][1]);
			fail_p[k] = sum_p[k] > rad_s2;
		end

		first = hint_s2[1:0];
		found = 1'b0;
		fidx  = first;
		for (int j = NUM_PLANES - 1; j >= 1; j--) begin
			idx = first + 2'(j);
			if (fail_h[idx]) begin
				found = 1'b1;
				fidx  = idx;
			end
		end

		culled = !nf_ok_s2 || (use_hint_s2 ? (|fail_h) : (|fail_p));
		res_c.depth = culled ? CULLED_DEPTH : depth_s2;
		if (nf_ok_s2 && use_hint_s2 && !fail_h[first] && found) begin
			res_c.new_hint = {6'd0, fidx};
		end else begin
			res_c.new_hint = hint_s2;
		end
	end

	cull_item_t res_s3;

	always_ff @(posedge clk) begin
		if (en3) res_s3 <= res_c;
	end

	assign result.valid = v_s3;
	assign result.data  = res_s3;

endmodule

`default_nettype wire

@@ bench/tb_frustum_sphere_cull.sv @@
// Testbench for frustum_sphere_cull: drives spheres and APB register writes, and checks
// every result against a predictor kept in a small scoreboard class.
// Depends on fsc_pkg, the channel interfaces in fsc_if and the block itself.
`timescale 1ns / 100ps

module tb_frustum_sphere_cull;
	import fsc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	class cull_scoreboard;
		logic signed [31:0] near_lim = '0;
		logic signed [31:0] far_lim  = '0;
		logic [47:0]        normal [NUM_PLANES] = '{default: '0};
		cull_item_t         expected_culls [$];
		int unsigned        faults = 0;

		function void set_register(reg_idx_t idx, logic [63:0] value);
			case (idx)
				REG_NEAR:   near_lim = value[31:0];
				REG_FAR:    far_lim = value[31:0];
				REG_PLANE0: normal[0] = value[47:0];
				REG_PLANE1: normal[1] = value[47:0];
				REG_PLANE2: normal[2] = value[47:0];
				REG_PLANE3: normal[3] = value[47:0];
				default: ;
			endcase
		endfunction

		function cull_item_t predict_cull(sphere_item_t s);
			longint             centre [NUM_AXES];
			longint             n, sum, plane_d, prod;
			logic [31:0]        part [NUM_AXES];
			logic signed [31:0] depth, lo, hi, rad, part_sum;
			int                 first, k;
			bit                 visible;
			cull_item_t         r;
			centre[0] = longint'($signed(s.point_x));
			centre[1] = longint'($signed(s.point_y));
			centre[2] = longint'($signed(s.point_z));
			rad = s.radius;
			depth = 32'd0 - s.point_z;
			lo = near_lim - rad;
			hi = far_lim + rad;
			visible = !(depth < lo || depth > hi);
			r.new_hint = s.hint_in;
			if (visible && s.use_hint) begin
				first = s.hint_in[1:0];
				for (int p = 0; p < NUM_PLANES; p++) begin
					k = (first + p) % NUM_PLANES;
					sum = 0;
					for (int a = 0; a < NUM_AXES; a++) begin
						n = longint'($signed(normal[k][16*a +: 16]));
						sum += centre[a] * n;
					end
					plane_d = (sum + longint'(ROUND_BIAS)) >>> FRAC_BITS;
					if (plane_d > longint'(rad)) begin
						visible = 1'b0;
						if (p != 0)
							r.new_hint = 8'(k);
						break;
					end
				end
			end else if (visible) begin
				for (k = 0; k < NUM_PLANES && visible; k++) begin
					for (int a = 0; a < NUM_AXES; a++) begin
						n = longint'($signed(normal[k][16*a +: 16]));
						prod = (centre[a] * n + longint'(ROUND_BIAS)) >>> FRAC_BITS;
						part[a] = prod[31:0];
					end
					part_sum = part[2] + (part[0] + part[1]);
					if (part_sum > rad)
						visible = 1'b0;
				end
			end
			r.depth = visible ? depth : CULLED_DEPTH;
			return r;
		endfunction

		function void note_sphere(sphere_item_t s);
			expected_culls.push_back(predict_cull(s));
		endfunction

		task report_mismatch(string msg);
			if (faults < 100)
				$display("MISMATCH at %0t: %s", $realtime, msg);
			faults++;
		endtask

		task check_cull(cull_item_t got);
			cull_item_t want;
			if (expected_culls.size() == 0) begin
				report_mismatch($sformatf("result with none expected: depth %h hint %h",
					got.depth, got.new_hint));
				return;
			end
			want = expected_culls.pop_front();
			if (got.depth !== want.depth)
				report_mismatch($sformatf("depth %h, expected %h", got.depth, want.depth));
			if (got.new_hint !== want.new_hint)
				report_mismatch($sformatf("new_hint %h, expected %h",
					got.new_hint, want.new_hint));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	bit          steady = 1'b0;
	int unsigned cycle_count = 0;

	cull_scoreboard culls = new();

	fsc_sphere_if sphere_ch();
	fsc_cull_if   result_ch();

	frustum_sphere_cull DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.sphere  (sphere_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("frustum_sphere_cull verification failed");
			$finish;
		end
	end

	// The receiver checks each result transfer and decides its ready for the next edge.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				culls.check_cull(result_ch.data);
			result_ch.ready <= steady || ($urandom_range(0, 99) >= 10);
		end
	end

	task automatic send_sphere(sphere_item_t item);
		while (!steady && $urandom_range(0, 99) < 10) begin
			sphere_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sphere_ch.valid <= 1'b1;
		sphere_ch.data  <= item;
		@(posedge clk);
		while (!sphere_ch.ready)
			@(posedge clk);
		culls.note_sphere(item);
	endtask

	task automatic wait_drained();
		sphere_ch.valid <= 1'b0;
		while (culls.expected_culls.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(reg_idx_t idx, logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		culls.set_register(idx, value);
	endtask

	task automatic program_frustum(logic [31:0] near_d, logic [31:0] far_d,
			logic [47:0] n0, logic [47:0] n1, logic [47:0] n2, logic [47:0] n3);
		wait_drained();
		write_register(REG_NEAR, {32'd0, near_d});
		write_register(REG_FAR, {32'd0, far_d});
		write_register(REG_PLANE0, {16'd0, n0});
		write_register(REG_PLANE1, {16'd0, n1});
		write_register(REG_PLANE2, {16'd0, n2});
		write_register(REG_PLANE3, {16'd0, n3});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic logic [47:0] random_normal();
		logic [15:0] comp [NUM_AXES];
		for (int a = 0; a < NUM_AXES; a++)
			comp[a] = 16'($urandom_range(0, 32'h2000) - 32'h1000);
		return {comp[2], comp[1], comp[0]};
	endfunction

	function automatic logic [31:0] extreme_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'h0000_0001;
			default: return $urandom();
		endcase
	endfunction

	// Mostly spheres in front of the viewer with modest radii, so that the plane tests
	// are reached; the rest are raw random words and extreme values.
	function automatic sphere_item_t random_sphere();
		sphere_item_t s;
		int unsigned  pick, span;
		pick = $urandom_range(0, 99);
		s.use_hint = 1'($urandom_range(0, 1));
		s.hint_in  = 8'($urandom_range(0, 255));
		if (pick < 65) begin
			span = $urandom_range(1, 32'h10_0000);
			s.point_x = $urandom_range(0, 2 * span) - span;
			s.point_y = $urandom_range(0, 2 * span) - span;
			s.point_z = 32'd0 - $urandom_range(0, 32'h10_0000);
			s.radius  = $urandom_range(0, 32'h8000);
		end else if (pick < 85) begin
			s.point_x = $urandom();
			s.point_y = $urandom();
			s.point_z = $urandom();
			s.radius  = $urandom();
		end else begin
			s.point_x = extreme_word();
			s.point_y = extreme_word();
			s.point_z = extreme_word();
			s.radius  = extreme_word();
		end
		return s;
	endfunction

	task automatic run_spheres(int count);
		repeat (count)
			send_sphere(random_sphere());
	endtask

	initial begin
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		sphere_ch.valid = 1'b0;
		sphere_ch.data  = '0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_spheres(40);

		program_frustum(32'h0000_1000, 32'h0006_4000, 48'h0000_0000_1000,
			48'h0000_0000_F000, 48'h0000_1000_0000, 48'h0000_F000_0000);
		send_sphere(sphere_item_t'{32'h0, 32'h0, -32'sh0000_A000, 32'h1000, 1'b0, 8'h00});
		send_sphere(sphere_item_t'{32'h0, 32'h0, -32'sh0000_A000, 32'h1000, 1'b1, 8'hFF});
		send_sphere(sphere_item_t'{32'h0, 32'h0, -32'sh0000_0800, 32'h0100, 1'b1, 8'h02});
		send_sphere(sphere_item_t'{32'h0, 32'h0, -32'sh0007_0000, 32'h1000, 1'b0, 8'h01});
		send_sphere(sphere_item_t'{32'h5000, 32'h0, -32'sh0000_A000, 32'h1000, 1'b0, 8'h00});
		send_sphere(sphere_item_t'{32'h5000, 32'h0, -32'sh0000_A000, 32'h1000, 1'b1, 8'h00});
		send_sphere(sphere_item_t'{32'h5000, 32'h0, -32'sh0000_A000, 32'h1000, 1'b1, 8'h01});
		send_sphere(sphere_item_t'{-32'sh5000, 32'h0, -32'sh0000_A000, 32'h1000, 1'b1, 8'h02});
		send_sphere(sphere_item_t'{32'h0, 32'h5000, -32'sh0000_A000, 32'h1000, 1'b1, 8'hE3});
		send_sphere(sphere_item_t'{32'h0, -32'sh5000, -32'sh0000_A000, 32'h1000, 1'b1, 8'h7C});
		send_sphere(sphere_item_t'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			1'b0, 8'h55});
		send_sphere(sphere_item_t'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			1'b1, 8'hAA});
		send_sphere(sphere_item_t'{32'h0, 32'h0, 32'h0, 32'h8000_0000, 1'b0, 8'h00});
		send_sphere(sphere_item_t'{32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1, 8'h03});
		send_sphere(sphere_item_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b1, 8'hFF});
		send_sphere(sphere_item_t'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			1'b1, 8'h01});
		run_spheres(80);
		wait_drained();
		run_spheres(80);

		steady = 1'b1;
		program_frustum(32'h8000_0000, 32'h7FFF_FFFF, 48'h8000_8000_8000,
			48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
		run_spheres(150);
		steady = 1'b0;

		program_frustum(32'h7FFF_FFFF, 32'h8000_0000, 48'h7FFF_7FFF_7FFF,
			48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
		run_spheres(150);

		program_frustum($urandom(), $urandom(), 48'({$urandom(), $urandom()}),
			48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
			48'({$urandom(), $urandom()}));
		run_spheres(150);

		repeat (2) begin
			program_frustum($urandom_range(0, 32'h4000), $urandom_range(32'h4_0000, 32'h20_0000),
				random_normal(), random_normal(), random_normal(), random_normal());
			run_spheres(120);
		end

		wait_drained();
		repeat (8)
			@(posedge clk);
		if (culls.faults == 0)
			$display("frustum_sphere_cull verification clean");
		else
			$display("frustum_sphere_cull verification failed");
		$finish;
	end

endmodule

@@ frustum_sphere_cull.f @@
rtl/fsc_pkg.sv
rtl/fsc_if.sv
rtl/frustum_sphere_cull.sv
bench/tb_frustum_sphere_cull.sv
